FILE: src/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Status codes, opcodes, sequencer states and the control structs that
// travel between the top level and the sequencer.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_TAG_BITS      = 16;
  localparam int DEF_PRIORITY_BITS = 8;
  localparam int STATUS_BITS       = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PLACE,
    S_REM_HEAD,
    S_REM_SHIFT,
    S_DONE
  } seq_state_t;

  // command from the top level: start a walk for the item being transferred
  typedef struct packed {
    logic start;
    op_t  op;
  } seq_cmd_t;

  // response to the top level: walk finished, result held until taken
  typedef struct packed {
    logic    done;
    status_t status;
  } seq_rsp_t;

endpackage

FILE: src/spq_if.sv
// ---------------------------------------------------------------------------
// spq_in_if / spq_out_if: command and result channels
// Valid/ready channels; a transfer happens at a clock edge with both high.
// ---------------------------------------------------------------------------
interface spq_in_if #(
  parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS,
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
);
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [PRIORITY_BITS-1:0] entry_priority;
  logic [TAG_BITS-1:0]      client_tag;

  modport source (output valid, output opcode, output entry_priority, output client_tag,
                  input ready);
  modport sink   (input valid, input opcode, input entry_priority, input client_tag,
                  output ready);
endinterface

interface spq_out_if #(
  parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS,
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
  parameter int OCC_BITS      = $clog2(spq_pkg::DEF_QUEUE_DEPTH + 1)
);
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STATUS_BITS-1:0] status;
  logic [TAG_BITS-1:0]           out_tag;
  logic [PRIORITY_BITS-1:0]      out_priority;
  logic [OCC_BITS-1:0]           occupancy;

  modport source (output valid, output status, output out_tag, output out_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_tag, input out_priority,
                  input occupancy, output ready);
endinterface

FILE: src/spq_mem.sv
// ---------------------------------------------------------------------------
// spq_mem: slot storage
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module spq_mem #(
  parameter int DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int WIDTH = spq_pkg::DEF_TAG_BITS + spq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] slots [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
    rd_data <= slots[rd_addr];
  end

endmodule

FILE: src/spq_seq.sv
// ---------------------------------------------------------------------------
// spq_seq: walk sequencer
// Runs one insert or remove over the slot memory, one slot per cycle,
// with a single priority comparator, and keeps the entry count.
// ---------------------------------------------------------------------------
module spq_seq #(
  parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS,
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  spq_pkg::seq_cmd_t                       cmd,
  input  logic [PRIORITY_BITS-1:0]                in_prio,
  input  logic [TAG_BITS-1:0]                     in_tag,
  input  logic                                    take,
  output spq_pkg::seq_rsp_t                       rsp,
  output logic [TAG_BITS-1:0]                     res_tag,
  output logic [PRIORITY_BITS-1:0]                res_prio,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        occupancy,
  output logic                                    wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]          wr_addr,
  output logic [TAG_BITS+PRIORITY_BITS-1:0]       wr_data,
  output logic [$clog2(QUEUE_DEPTH)-1:0]          rd_addr,
  input  logic [TAG_BITS+PRIORITY_BITS-1:0]       rd_data
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = TAG_BITS + PRIORITY_BITS;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);
  localparam logic [IDX_W-1:0] ONE_IDX    = IDX_W'(1);
  localparam logic [IDX_W-1:0] TWO_IDX    = IDX_W'(2);

  seq_state_t               state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         pos, pos_next;
  logic [PRIORITY_BITS-1:0] item_prio;
  logic [TAG_BITS-1:0]      item_tag;
  status_t                  status, status_next;
  logic [TAG_BITS-1:0]      res_tag_next;
  logic [PRIORITY_BITS-1:0] res_prio_next;

  logic [PRIORITY_BITS-1:0] slot_prio;
  logic [ENT_W-1:0]         item_word;

  assign slot_prio = rd_data[ENT_W-1 -: PRIORITY_BITS];
  assign item_word = {item_prio, item_tag};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    status   <= status_next;
    res_tag  <= res_tag_next;
    res_prio <= res_prio_next;
    if (state == S_IDLE && cmd.start) begin
      item_prio <= in_prio;
      item_tag  <= in_tag;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    status_next   = status;
    res_tag_next  = res_tag;
    res_prio_next = res_prio;
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = item_word;
    rd_addr       = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd.start) begin
          res_tag_next  = '0;
          res_prio_next = '0;
          if (cmd.op == OP_INSERT) begin
            if (count == FULL_COUNT) begin
              status_next = ST_FULL;
              state_next  = S_DONE;
            end else if (count == '0) begin
              // empty queue: place at the head at once
              wr_en       = 1'b1;
              wr_addr     = '0;
              wr_data     = {in_prio, in_tag};
              count_next  = ONE_COUNT;
              status_next = ST_INSERTED;
              state_next  = S_DONE;
            end else begin
              pos_next   = count[IDX_W-1:0];
              rd_addr    = count[IDX_W-1:0] - ONE_IDX;
              state_next = S_INS_CMP;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_DONE;
            end else begin
              rd_addr    = '0;
              state_next = S_REM_HEAD;
            end
          end
        end
      end

      S_INS_CMP: begin
        // rd_data holds slot pos-1; shift it up while it sorts after the item
        wr_en = 1'b1;
        if (slot_prio > item_prio) begin
          wr_data = rd_data;
          if (pos == ONE_IDX) begin
            pos_next   = '0;
            state_next = S_INS_PLACE;
          end else begin
            rd_addr  = pos - TWO_IDX;
            pos_next = pos - ONE_IDX;
          end
        end else begin
          count_next  = count + ONE_COUNT;
          status_next = ST_INSERTED;
          state_next  = S_DONE;
        end
      end

      S_INS_PLACE: begin
        wr_en       = 1'b1;
        count_next  = count + ONE_COUNT;
        status_next = ST_INSERTED;
        state_next  = S_DONE;
      end

      S_REM_HEAD: begin
        res_tag_next  = rd_data[TAG_BITS-1:0];
        res_prio_next = slot_prio;
        status_next   = ST_REMOVED;
        if (count == ONE_COUNT) begin
          count_next = '0;
          state_next = S_DONE;
        end else begin
          rd_addr    = ONE_IDX;
          pos_next   = ONE_IDX;
          state_next = S_REM_SHIFT;
        end
      end

      S_REM_SHIFT: begin
        // rd_data holds slot pos; move it down one place
        wr_en   = 1'b1;
        wr_addr = pos - ONE_IDX;
        wr_data = rd_data;
        if (CNT_W'(pos) + ONE_COUNT < count) begin
          rd_addr  = pos + ONE_IDX;
          pos_next = pos + ONE_IDX;
        end else begin
          count_next = count - ONE_COUNT;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign rsp       = '{done: (state == S_DONE), status: status};
  assign occupancy = count;

endmodule

FILE: src/stable_priority_queue_core.sv
// ---------------------------------------------------------------------------
// stable_priority_queue_core: sorted priority queue with stable ordering
// Bounded queue kept sorted by ascending priority; equal priorities leave in
// arrival order.
// ---------------------------------------------------------------------------
// Usage:
//   req  carries one command per transfer: opcode insert (tag + priority) or
//        remove (pop head). rsp carries exactly one result per command:
//        status, removed tag/priority (zero unless removed) and occupancy.
//   The sequencer walks the slot memory one slot per cycle through its single
//   read and write port; req.ready stays low while a command is in flight, so
//   commands are handled one at a time, and it rises again once the result
//   is loaded into the rsp output register.
//   A finished result sits in the rsp output register. req accepts the next
//   command while that result waits; if the receiver still stalls when the
//   next result is ready, the sequencer holds it until the register frees.
//   Reset empties the queue (entry count to zero) and drops any pending
//   result; slot contents are left as they are and never read until written.
// ---------------------------------------------------------------------------
module stable_priority_queue_core #(
  parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS,
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
  input logic       clk,
  input logic       rst,
  spq_in_if.sink    req,
  spq_out_if.source rsp
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = TAG_BITS + PRIORITY_BITS;

  logic                     busy;
  logic                     req_xfer;
  logic                     take;
  seq_cmd_t                 cmd;
  seq_rsp_t                 seq_rsp;
  logic [TAG_BITS-1:0]      res_tag;
  logic [PRIORITY_BITS-1:0] res_prio;
  logic [CNT_W-1:0]         seq_occ;

  logic                     mem_wr_en;
  logic [IDX_W-1:0]         mem_wr_addr;
  logic [ENT_W-1:0]         mem_wr_data;
  logic [IDX_W-1:0]         mem_rd_addr;
  logic [ENT_W-1:0]         mem_rd_data;

  logic                     out_valid;
  logic [STATUS_BITS-1:0]   out_status;
  logic [TAG_BITS-1:0]      out_tag;
  logic [PRIORITY_BITS-1:0] out_prio;
  logic [CNT_W-1:0]         out_occ;

  // Take a new command only when no command is in flight.
  assign req.ready = !busy;
  assign req_xfer  = req.valid && !busy;

  assign cmd = '{start: req_xfer, op: op_t'(req.opcode)};

  // Load the output register when the sequencer is done and the register
  // is empty or being drained in this cycle.
  assign take = seq_rsp.done && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_xfer) begin
        busy <= 1'b1;
      end else if (take) begin
        busy <= 1'b0;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold payload until the result transfer completes.
  always_ff @(posedge clk) begin
    if (take) begin
      out_status <= seq_rsp.status;
      out_tag    <= res_tag;
      out_prio   <= res_prio;
      out_occ    <= seq_occ;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_tag      = out_tag;
  assign rsp.out_priority = out_prio;
  assign rsp.occupancy    = out_occ;

  spq_seq #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TAG_BITS     (TAG_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_prio  (req.entry_priority),
    .in_tag   (req.client_tag),
    .take     (take),
    .rsp      (seq_rsp),
    .res_tag  (res_tag),
    .res_prio (res_prio),
    .occupancy(seq_occ),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data),
    .rd_addr  (mem_rd_addr),
    .rd_data  (mem_rd_data)
  );

  spq_mem #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(ENT_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule

FILE: src/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker: port-level checks of the priority queue
// Watches the req and rsp channels of the top level.
// ---------------------------------------------------------------------------
module spq_checker #(
  parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [spq_pkg::STATUS_BITS-1:0]    rsp_status,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_occupancy))
    else $error("rsp dropped or changed while stalled");

  // drop req.ready after a command transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second command taken while one is in flight");

  // full-drop and empty-remove statuses agree with the occupancy
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == CNT_W'(QUEUE_DEPTH))
    else $error("full status with queue not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0)
    else $error("empty status with queue not empty");

  // a successful insert leaves at least one entry; a remove leaves room
  a_op_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_INSERTED || rsp_status == ST_REMOVED) |->
      (rsp_status == ST_INSERTED) ? (rsp_occupancy != '0)
                                  : (rsp_occupancy < CNT_W'(QUEUE_DEPTH)))
    else $error("occupancy out of range for status");

endmodule

bind stable_priority_queue_core spq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_occupancy(rsp.occupancy)
);
